>>> src/rraa_pkg.sv
// Package for the rate adaptation unit: widths, item codes, table entry type.
// Used by rraa_ram's users and by robust_rate_adaptation_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rraa_pkg;

   localparam int MAX_RATES   = 16;
   localparam int RATE_BITS   = $clog2(MAX_RATES);
   localparam int RATE_LIMIT  = (MAX_RATES < 16) ? MAX_RATES : 16;
   localparam int WINDOW_BITS = 12;
   localparam int LOSS_BITS   = 17;
   localparam int TICK_BITS   = 24;
   localparam int RTS_BITS    = 16;
   localparam int NRATE_BITS  = 5;
   localparam int Q16_SHIFT   = 16;
   localparam int PROD_BITS   = LOSS_BITS + WINDOW_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 24;

   // Item kinds carried on req_tuser
   typedef enum logic [2:0] {
      FUNC_LOAD    = 3'd0,
      FUNC_RESTART = 3'd1,
      FUNC_OK      = 3'd2,
      FUNC_FAIL    = 3'd3,
      FUNC_RTS     = 3'd4,
      FUNC_TICK    = 3'd5
   } func_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BASIC_MODE = 2'd0,
      CSR_TIMEOUT    = 2'd1,
      CSR_NUM_RATES  = 2'd2
   } csr_index_type;

   // One threshold table entry as held in memory
   typedef struct packed {
      logic [LOSS_BITS-1:0]   min_loss;
      logic [LOSS_BITS-1:0]   max_loss;
      logic [WINDOW_BITS-1:0] window;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

`default_nettype wire

>>> src/rraa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read returns the old contents on a same-address write.
`timescale 1ns / 1ps
`default_nettype none

module rraa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/robust_rate_adaptation_unit.sv
// Top level of the per-link rate adaptation unit: item decode, window and loss
// logic, adaptive RTS, output skid stage. Depends on rraa_pkg and rraa_ram.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-------------------------------------
//  req     | in  | req_tvalid / req_tready | req_tuser func, req_tdata fields
//  rsp     | out | rsp_tvalid / rsp_tready | rsp_tdata rate_index, use_rts
//  csr     | in  | csr_valid / csr_ready   | csr_index, csr_data
//
// One item per cycle while req_tready is high; results are registered at the output.
// The threshold table sits in a RAM read every cycle at the next current rate,
// so after a rate change the new window length is fetched in the following
// cycle (a pending flag covers that cycle). No clearing pass after reset.
// A full output plus skid register drops req_tready; csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module robust_rate_adaptation_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // req: rate_slot[3:0] window[15:4] max_loss[32:16] min_loss[49:33]
   //      rts_normally[50], zero above
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic [2:0]  req_tuser,    // func[2:0]
   // rsp: rate_index[3:0] use_rts[4], zero above
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   localparam int RB = rraa_pkg::RATE_BITS;
   localparam int WB = rraa_pkg::WINDOW_BITS;
   localparam int TB = rraa_pkg::TICK_BITS;
   localparam int SB = rraa_pkg::RTS_BITS;
   localparam int PB = rraa_pkg::PROD_BITS;

   // configuration registers
   logic                          basic_mode_ff;
   logic [TB-1:0]                 timeout_ff;
   logic [rraa_pkg::NRATE_BITS-1:0] num_rates_ff;

   // link state
   logic [RB-1:0] current_rate_ff, current_rate_in;
   logic [WB-1:0] frames_left_ff,  frames_left_in;
   logic [WB-1:0] failures_ff,     failures_in;
   logic [TB-1:0] elapsed_ff,      elapsed_in;
   logic [SB-1:0] rts_window_ff,   rts_window_in;
   logic [SB-1:0] rts_left_ff,     rts_left_in;
   logic          rts_active_ff,   rts_active_in;
   logic          last_failed_ff,  last_failed_in;
   logic          pend_ff,         pend_in;

   // memory read bypass
   logic                bypass_hit_ff, bypass_hit_in;
   rraa_pkg::entry_type bypass_ff;
   rraa_pkg::entry_type ram_rd;
   rraa_pkg::entry_type ent;
   rraa_pkg::entry_type new_entry;

   // output and skid registers
   logic          out_valid_ff, skid_valid_ff;
   logic [RB-1:0] out_rate_ff, skid_rate_ff;
   logic          out_rts_ff, skid_rts_ff;
   logic          out_free;

   // item fields
   rraa_pkg::func_type func;
   logic [RB-1:0]      slot;
   logic               rts_normally;
   logic               accept;
   logic               load_wr;

   // frame report datapath
   logic [RB-1:0] top_rate;
   logic [WB-1:0] fl_eff, fl1, fl2, fa1, fa2;
   logic [TB-1:0] el1;
   logic          open1, failed;
   logic [PB-1:0] fail_scaled, prod_max, prod_min;
   logic          step_down, step_up;

   assign func         = rraa_pkg::func_type'(req_tuser);
   assign slot         = req_tdata[RB-1:0];
   assign new_entry.window   = req_tdata[15:4];
   assign new_entry.max_loss = req_tdata[32:16];
   assign new_entry.min_loss = req_tdata[49:33];
   assign rts_normally = req_tdata[50];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign load_wr    = accept && (func == rraa_pkg::FUNC_LOAD);
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         basic_mode_ff <= 1'b0;
         timeout_ff    <= TB'(50);
         num_rates_ff  <= rraa_pkg::NRATE_BITS'(8);
      end else if (csr_valid && csr_ready) begin
         unique case (rraa_pkg::csr_index_type'(csr_index))
            rraa_pkg::CSR_BASIC_MODE: basic_mode_ff <= csr_data[0];
            rraa_pkg::CSR_TIMEOUT:    timeout_ff    <= csr_data[TB-1:0];
            rraa_pkg::CSR_NUM_RATES:  num_rates_ff  <= csr_data[rraa_pkg::NRATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // top rate index from the clamped rate count
   always_comb begin
      if (num_rates_ff == '0) begin
         top_rate = '0;
      end else if (num_rates_ff > rraa_pkg::NRATE_BITS'(rraa_pkg::RATE_LIMIT)) begin
         top_rate = RB'(rraa_pkg::RATE_LIMIT - 1);
      end else begin
         top_rate = RB'(num_rates_ff - 1'b1);
      end
   end

   // threshold table, read each cycle at the rate the next cycle works with
   rraa_ram #(
      .WIDTH (rraa_pkg::ENTRY_BITS),
      .DEPTH (rraa_pkg::MAX_RATES)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (slot),
      .wr_data (new_entry),
      .rd_addr (current_rate_in),
      .rd_data (ram_rd)
   );

   assign bypass_hit_in = load_wr && (slot == current_rate_in);
   assign ent           = bypass_hit_ff ? bypass_ff : ram_rd;

   // frame report: window restart, countdown, tally and loss compares
   assign failed      = (func == rraa_pkg::FUNC_FAIL);
   assign fl_eff      = pend_ff ? ent.window : frames_left_ff;
   assign open1       = (fl_eff == '0) || (elapsed_ff > timeout_ff);
   assign fl1         = open1 ? ent.window : fl_eff;
   assign fa1         = open1 ? '0 : failures_ff;
   assign el1         = open1 ? '0 : elapsed_ff;
   assign fl2         = (fl1 != '0) ? fl1 - 1'b1 : fl1;
   assign fa2         = (failed && (fa1 != '1)) ? fa1 + 1'b1 : fa1;
   assign fail_scaled = PB'({fa2, {rraa_pkg::Q16_SHIFT{1'b0}}});
   assign prod_max    = PB'(ent.max_loss) * PB'(ent.window);
   assign prod_min    = PB'(ent.min_loss) * PB'(ent.window);
   assign step_down   = fail_scaled > prod_max;
   assign step_up     = (current_rate_ff < top_rate) && (fail_scaled < prod_min);

   // next link state
   always_comb begin
      current_rate_in = current_rate_ff;
      frames_left_in  = fl_eff;
      failures_in     = failures_ff;
      elapsed_in      = elapsed_ff;
      rts_window_in   = rts_window_ff;
      rts_left_in     = rts_left_ff;
      rts_active_in   = rts_active_ff;
      last_failed_in  = last_failed_ff;
      pend_in         = 1'b0;
      if (accept) begin
         unique case (func) inside
            rraa_pkg::FUNC_LOAD: ;
            rraa_pkg::FUNC_RESTART: begin
               current_rate_in = top_rate;
               pend_in         = 1'b1;
               failures_in     = '0;
               elapsed_in      = '0;
            end
            rraa_pkg::FUNC_OK, rraa_pkg::FUNC_FAIL: begin
               last_failed_in = failed;
               if (step_down || (fl2 == '0)) begin
                  if (step_down) begin
                     if (current_rate_ff != '0) begin
                        current_rate_in = current_rate_ff - 1'b1;
                     end
                  end else if (step_up) begin
                     current_rate_in = current_rate_ff + 1'b1;
                  end
                  pend_in     = 1'b1;
                  failures_in = '0;
                  elapsed_in  = '0;
               end else begin
                  frames_left_in = fl2;
                  failures_in    = fa2;
                  elapsed_in     = el1;
               end
            end
            rraa_pkg::FUNC_RTS: begin
               if (basic_mode_ff) begin
                  rts_active_in = rts_normally;
               end else begin
                  if (!rts_active_ff && last_failed_ff) begin
                     if (rts_window_ff != '1) begin
                        rts_window_in = rts_window_ff + 1'b1;
                     end
                     rts_left_in = rts_window_in;
                  end else if (rts_active_ff == last_failed_ff) begin
                     rts_window_in = rts_window_ff >> 1;
                     rts_left_in   = rts_window_in;
                  end
                  if (rts_left_in != '0) begin
                     rts_active_in = 1'b1;
                     rts_left_in   = rts_left_in - 1'b1;
                  end else begin
                     rts_active_in = 1'b0;
                  end
               end
            end
            rraa_pkg::FUNC_TICK: begin
               if (elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         current_rate_ff <= '0;
         frames_left_ff  <= '0;
         failures_ff     <= '0;
         elapsed_ff      <= '0;
         rts_window_ff   <= '0;
         rts_left_ff     <= '0;
         rts_active_ff   <= 1'b0;
         last_failed_ff  <= 1'b0;
         pend_ff         <= 1'b0;
         bypass_hit_ff   <= 1'b0;
      end else begin
         current_rate_ff <= current_rate_in;
         frames_left_ff  <= frames_left_in;
         failures_ff     <= failures_in;
         elapsed_ff      <= elapsed_in;
         rts_window_ff   <= rts_window_in;
         rts_left_ff     <= rts_left_in;
         rts_active_ff   <= rts_active_in;
         last_failed_ff  <= last_failed_in;
         pend_ff         <= pend_in;
         bypass_hit_ff   <= bypass_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      bypass_ff <= new_entry;
   end

   // output register with skid stage
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_rate_ff <= skid_rate_ff;
            out_rts_ff  <= skid_rts_ff;
         end
      end else if (accept) begin
         if (out_free) begin
            out_rate_ff <= current_rate_in;
            out_rts_ff  <= rts_active_in;
         end else begin
            skid_rate_ff <= current_rate_in;
            skid_rts_ff  <= rts_active_in;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_rts_ff, out_rate_ff};

`ifndef SYNTHESIS
   // a held skid transaction always sits behind a valid output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // a restart leaves a window length fetch pending at the top rate
   a_restart_pend: assert property (@(posedge clock) disable iff (reset)
      (accept && (func == rraa_pkg::FUNC_RESTART)) |=>
         (pend_ff && (failures_ff == '0) && (elapsed_ff == '0)))
      else $error("restart did not open a new window");

   // a frame report records its outcome for the RTS logic
   a_last_failed: assert property (@(posedge clock) disable iff (reset)
      (accept && (func == rraa_pkg::FUNC_FAIL)) |=> last_failed_ff)
      else $error("failed frame not recorded");
`endif

endmodule

`default_nettype wire

>>> test/robust_rate_adaptation_unit_test.sv
// Self-checking bench for robust_rate_adaptation_unit: random and directed items with an
// in-bench rate/RTS predictor, random idling on both streams and several CSR settings.
// Depends on rraa_pkg and the unit's RTL only.
`timescale 1ns / 1ps
`default_nettype none

module robust_rate_adaptation_unit_test;
   import rraa_pkg::*;

   // Spare item kinds, which must leave the state alone
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam int NUM_PHASES   = 10;
   localparam int PHASE_ITEMS  = 175;
   localparam int DRAIN_CYCLES = 6;

   typedef struct {
      logic [2:0]             func;
      logic [3:0]             slot;
      logic [WINDOW_BITS-1:0] window;
      logic [LOSS_BITS-1:0]   max_loss;
      logic [LOSS_BITS-1:0]   min_loss;
      logic                   rts_normally;
   } rate_item_type;

   typedef struct {
      logic [RATE_BITS-1:0] rate_index;
      logic                 use_rts;
   } rate_decision_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [23:0] csr_data   = '0;

   robust_rate_adaptation_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: threshold table, loss window, adaptive RTS and CSR copies
   entry_type              rate_table [MAX_RATES];
   logic [RATE_BITS-1:0]   cur_rate      = '0;
   logic [WINDOW_BITS-1:0] frames_left   = '0;
   logic [WINDOW_BITS-1:0] fail_count    = '0;
   logic [TICK_BITS-1:0]   tick_count    = '0;
   logic [RTS_BITS-1:0]    rts_span      = '0;
   logic [RTS_BITS-1:0]    rts_remaining = '0;
   logic                   rts_on        = 1'b0;
   logic                   last_fail     = 1'b0;
   logic                   cfg_basic     = 1'b0;
   logic [TICK_BITS-1:0]   cfg_timeout   = 24'd50;
   logic [NRATE_BITS-1:0]  cfg_num_rates = 5'd8;

   rate_item_type     pending_items [$];
   rate_decision_type decisions_due [$];
   rate_item_type     item_on_bus;
   int                queued_count   = 0;
   int                accepted_count = 0;
   int                send_gap       = 0;
   int                rsp_count      = 0;
   int                mismatches     = 0;
   int                hold_left      = 0;
   int                next_hold_mark = 300;
   bit                gaps_on        = 1'b1;

   function automatic logic [RATE_BITS-1:0] top_index();
      int n;
      n = int'(cfg_num_rates);
      if (n < 1) n = 1;
      if (n > RATE_LIMIT) n = RATE_LIMIT;
      return RATE_BITS'(n - 1);
   endfunction

   function automatic void open_window();
      fail_count  = '0;
      frames_left = rate_table[cur_rate].window;
      tick_count  = '0;
   endfunction

   // Advances the predicted state by one item and returns the rate decision it yields
   function automatic rate_decision_type apply_rate_item(rate_item_type it);
      rate_decision_type d;
      longint unsigned   fails_q16, max_bound, min_bound;
      logic              failed;
      case (it.func) inside
         FUNC_LOAD: begin
            rate_table[it.slot].window   = it.window;
            rate_table[it.slot].max_loss = it.max_loss;
            rate_table[it.slot].min_loss = it.min_loss;
         end
         FUNC_RESTART: begin
            cur_rate = top_index();
            open_window();
         end
         FUNC_OK, FUNC_FAIL: begin
            failed    = (it.func == FUNC_FAIL);
            last_fail = failed;
            // stale or timed-out window restarts before the frame is counted
            if (frames_left == 0 || tick_count > cfg_timeout) open_window();
            if (frames_left > 0) frames_left--;
            if (failed && fail_count != '1) fail_count++;
            // exact loss compare: failures * 2^16 against threshold * window
            fails_q16 = 64'(fail_count);
            fails_q16 = fails_q16 << Q16_SHIFT;
            max_bound = 64'(rate_table[cur_rate].max_loss);
            max_bound = max_bound * 64'(rate_table[cur_rate].window);
            min_bound = 64'(rate_table[cur_rate].min_loss);
            min_bound = min_bound * 64'(rate_table[cur_rate].window);
            if (fails_q16 > max_bound) begin
               if (cur_rate > 0) cur_rate--;
               open_window();
            end else if (frames_left == 0) begin
               if (cur_rate < top_index() && fails_q16 < min_bound) cur_rate++;
               open_window();
            end
         end
         FUNC_RTS: begin
            if (cfg_basic) begin
               rts_on = it.rts_normally;
            end else begin
               // grow after a failure without RTS, halve when RTS state matched outcome
               if (!rts_on && last_fail) begin
                  if (rts_span != '1) rts_span++;
                  rts_remaining = rts_span;
               end else if (rts_on == last_fail) begin
                  rts_span      = rts_span >> 1;
                  rts_remaining = rts_span;
               end
               if (rts_remaining > 0) begin
                  rts_on = 1'b1;
                  rts_remaining--;
               end else begin
                  rts_on = 1'b0;
               end
            end
         end
         FUNC_TICK: begin
            if (tick_count != '1) tick_count++;
         end
         default: ;
      endcase
      d.rate_index = cur_rate;
      d.use_rts    = rts_on;
      return d;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic rate_item_type random_fields(logic [2:0] func);
      rate_item_type it;
      it.func         = func;
      it.slot         = 4'($urandom);
      it.window       = WINDOW_BITS'($urandom);
      it.max_loss     = LOSS_BITS'($urandom);
      it.min_loss     = LOSS_BITS'($urandom);
      it.rts_normally = 1'($urandom);
      return it;
   endfunction

   function automatic rate_item_type random_item(int fail_pct);
      rate_item_type it;
      int r;
      it = random_fields(FUNC_TICK);
      r  = $urandom_range(0, 99);
      if (r < 4) begin
         // table reload, mostly short windows and sensible thresholds
         it.func = FUNC_LOAD;
         r = $urandom_range(0, 9);
         if (r < 8) it.window = WINDOW_BITS'($urandom_range(1, 16));
         else if (r == 8) it.window = '0;
         if ($urandom_range(0, 3) != 0) begin
            it.max_loss = LOSS_BITS'($urandom_range(8192, 40000));
            it.min_loss = LOSS_BITS'($urandom_range(0, 12000));
         end
      end else if (r < 7) begin
         it.func = FUNC_RESTART;
      end else if (r < 62) begin
         it.func = ($urandom_range(0, 99) < fail_pct) ? FUNC_FAIL : FUNC_OK;
      end else if (r < 78) begin
         it.func = FUNC_RTS;
      end else if (r >= 97) begin
         it.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      end
      return it;
   endfunction

   function automatic void post_item(rate_item_type it);
      pending_items = {pending_items, it};
      queued_count++;
   endfunction

   // Request driver: one transaction per handshake, random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            decisions_due = {decisions_due, apply_rate_item(item_on_bus)};
            accepted_count++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            item_on_bus = pending_items.pop_front();
            req_tuser  <= item_on_bus.func;
            req_tdata  <= {5'b0, item_on_bus.rts_normally, item_on_bus.min_loss,
                           item_on_bus.max_loss, item_on_bus.window, item_on_bus.slot};
            req_tvalid <= 1'b1;
            send_gap    = gaps_on ? random_gap() : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_count >= next_hold_mark && req_tvalid && pending_items.size() > 20) begin
         hold_left = $urandom_range(150, 250);
         next_hold_mark += 700;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
         hold_left = random_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Response monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin
      rate_decision_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (decisions_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got rate_index %0d use_rts %0b",
                     $time, rsp_tdata[3:0], rsp_tdata[4]);
            mismatches++;
         end else begin
            want = decisions_due.pop_front();
            if (rsp_tdata[3:0] !== want.rate_index) begin
               $display("%0t: rate_index mismatch, expected %0d, got %0d",
                        $time, want.rate_index, rsp_tdata[3:0]);
               mismatches++;
            end
            if (rsp_tdata[4] !== want.use_rts) begin
               $display("%0t: use_rts mismatch, expected %0b, got %0b",
                        $time, want.use_rts, rsp_tdata[4]);
               mismatches++;
            end
         end
      end
   end

   // Register write; leaves csr_valid high so writes can run back to back
   task automatic csr_write(csr_index_type idx, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BASIC_MODE: cfg_basic     = value[0];
         CSR_TIMEOUT:    cfg_timeout   = value;
         CSR_NUM_RATES:  cfg_num_rates = value[NRATE_BITS-1:0];
         default: ;
      endcase
   endtask

   // Wait until every prediction is matched, then let the unit settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (accepted_count != queued_count || decisions_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus: directed opening, then phases of random items under varied settings
   initial begin
      rate_item_type it;
      logic          basic_val;
      logic [23:0]   timeout_val, rates_val;
      int            fail_pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table first so no entry is ever read unwritten
      for (int s = 0; s < MAX_RATES; s++) begin
         it = random_fields(FUNC_LOAD);
         it.slot         = 4'(s);
         it.rts_normally = s[0];
         it.window       = (s == 3) ? 12'd0 : (s == 15) ? 12'hFFF :
                           (s == 1) ? 12'd1 : 12'($urandom_range(2, 10));
         it.max_loss     = (s == 5) ? 17'd0 : (s == 6) ? 17'h1FFFF :
                           (s == 15) ? 17'd65536 : 17'($urandom_range(16384, 32768));
         it.min_loss     = (s == 7) ? 17'h1FFFF : (s == 2) ? 17'd0 :
                           17'($urandom_range(0, 8192));
         post_item(it);
      end
      post_item(random_fields(FUNC_RESTART));
      post_item(random_fields(FUNC_OK));
      post_item(random_fields(FUNC_FAIL));
      post_item(random_fields(FUNC_RTS));
      post_item(random_fields(FUNC_RTS));
      post_item(random_fields(FUNC_TICK));
      post_item(random_fields(FUNC_SPARE_LO));
      post_item(random_fields(FUNC_SPARE_HI));
      post_item(random_fields(FUNC_FAIL));
      post_item(random_fields(FUNC_RTS));
      wait_quiet();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            case (p)
               1: begin basic_val = 1'b0; timeout_val = 24'd1;       rates_val = 24'd16;      end
               2: begin basic_val = 1'b1; timeout_val = 24'hFFFFFF;  rates_val = 24'd1;       end
               3: begin basic_val = 1'b0; timeout_val = 24'd0;       rates_val = 24'd0;       end
               4: begin basic_val = 1'b1; timeout_val = 24'd5;       rates_val = 24'd31;      end
               5: begin basic_val = 1'b0; timeout_val = 24'd20;      rates_val = 24'hABCDE4;  end
               6: begin basic_val = 1'b0; timeout_val = 24'd3;       rates_val = 24'd16;      end
               7: begin basic_val = 1'b1; timeout_val = 24'd100;     rates_val = 24'd12;      end
               8: begin basic_val = 1'b0; timeout_val = 24'd2;       rates_val = 24'd2;       end
               default: begin
                  basic_val   = 1'($urandom_range(0, 1));
                  timeout_val = 24'($urandom_range(1, 64));
                  rates_val   = 24'($urandom_range(1, 16));
               end
            endcase
            csr_write(CSR_BASIC_MODE, {23'h5A5A5A, basic_val});
            csr_write(CSR_TIMEOUT, timeout_val);
            csr_write(CSR_NUM_RATES, rates_val);
            csr_valid <= 1'b0;
         end
         gaps_on  = (p % 4 != 3);
         fail_pct = (p == 0) ? 25 : $urandom_range(5, 45);
         for (int n = 0; n < PHASE_ITEMS; n++)
            post_item(random_item(fail_pct));
         wait_quiet();
      end

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
src/rraa_pkg.sv
src/rraa_ram.sv
src/robust_rate_adaptation_unit.sv
test/robust_rate_adaptation_unit_test.sv
